FILE: rtl/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg
// Shared types and codes for the ARM/Thumb relocation patcher: relocation
// type numbers, status codes and the item structs on both channels.
// ----------------------------------------------------------------------------
package atrp_pkg;

  localparam int unsigned HalfW = 16;
  localparam int unsigned AddrW = 32;
  localparam int unsigned TypeW = 8;
  localparam int unsigned StatW = 2;

  typedef enum logic [TypeW-1:0] {
    RELOC_ABS32      = 8'd2,
    RELOC_REL32      = 8'd3,
    RELOC_THM_CALL   = 8'd10,
    RELOC_THM_JUMP24 = 8'd30,
    RELOC_TARGET1    = 8'd38,
    RELOC_THM_MOVW   = 8'd47,
    RELOC_THM_MOVT   = 8'd48
  } reloc_e;

  typedef enum logic [StatW-1:0] {
    ST_PATCHED     = 2'd0,
    ST_RANGE       = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_e;

  typedef struct packed {
    logic [HalfW-1:0] site_low_half;
    logic [HalfW-1:0] site_high_half;
    logic [TypeW-1:0] opcode;
    logic [AddrW-1:0] symbol_address;
    logic [AddrW-1:0] site_address;
  } req_t;

  typedef struct packed {
    logic [HalfW-1:0] patched_low_half;
    logic [HalfW-1:0] patched_high_half;
    status_e          status;
  } rsp_t;

endpackage

FILE: rtl/atrp_if.sv
// ----------------------------------------------------------------------------
// atrp_if
// Valid/ready channels of the relocation patcher: the request channel carries
// one relocation site, the response channel the patched halfwords and status.
// ----------------------------------------------------------------------------
interface atrp_req_if
  import atrp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] site_low_half;
  logic [HalfW-1:0] site_high_half;
  logic [TypeW-1:0] opcode;
  logic [AddrW-1:0] symbol_address;
  logic [AddrW-1:0] site_address;

  modport source (
    output valid, site_low_half, site_high_half, opcode, symbol_address, site_address,
    input  ready
  );
  modport sink (
    input  valid, site_low_half, site_high_half, opcode, symbol_address, site_address,
    output ready
  );
endinterface

interface atrp_rsp_if
  import atrp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] patched_low_half;
  logic [HalfW-1:0] patched_high_half;
  logic [StatW-1:0] status;

  modport source (
    output valid, patched_low_half, patched_high_half, status,
    input  ready
  );
  modport sink (
    input  valid, patched_low_half, patched_high_half, status,
    output ready
  );
endinterface

FILE: rtl/arm_thumb_relocation_patcher.sv
// ----------------------------------------------------------------------------
// arm_thumb_relocation_patcher
// A request is captured in the input register (s1_req_q), then its patched
// result in out_q, which drives rsp_o. Throughput: one item per cycle while
// rsp_o.ready is high; the patch logic between the input and result registers,
// led by the three-operand 32-bit branch offset add, sets the pace.
// Reset clears the two stage valid flags only; payload registers are not reset.
// ----------------------------------------------------------------------------
module arm_thumb_relocation_patcher
  import atrp_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  atrp_req_if.sink      req_i,
  atrp_rsp_if.source    rsp_o
);

  logic s1_valid_q;
  req_t s1_req_q;
  logic s1_adv;
  logic out_valid_q;
  rsp_t out_q;
  rsp_t out_d;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q.site_low_half  <= req_i.site_low_half;
      s1_req_q.site_high_half <= req_i.site_high_half;
      s1_req_q.opcode         <= req_i.opcode;
      s1_req_q.symbol_address <= req_i.symbol_address;
      s1_req_q.site_address   <= req_i.site_address;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  atrp_patch u_patch (
    .req_i (s1_req_q),
    .rsp_o (out_d)
  );

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.patched_low_half  = out_q.patched_low_half;
  assign rsp_o.patched_high_half = out_q.patched_high_half;
  assign rsp_o.status            = out_q.status;

`ifndef NO_ASSERTIONS
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !(s1_valid_q && out_valid_q && !rsp_o.ready))
    else $error("request accepted while both stages are blocked");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("held item did not move into empty result register");

  a_unchanged_site: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (out_d.status != ST_PATCHED) |=>
      (out_q.patched_low_half == $past(s1_req_q.site_low_half)) &&
      (out_q.patched_high_half == $past(s1_req_q.site_high_half)))
    else $error("site changed for an unpatched item");
`endif

endmodule

FILE: rtl/atrp_patch.sv
// ----------------------------------------------------------------------------
// atrp_patch
// Patch datapath for one relocation site: data word adds, Thumb BL/B.W offset
// decode, range check and re-encode, and MOVW/MOVT imm16 field add.
// ----------------------------------------------------------------------------
module atrp_patch
  import atrp_pkg::*;
(
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [HalfW-1:0] lo;
  logic [HalfW-1:0] hi;
  logic [AddrW-1:0] word;
  logic [AddrW-1:0] abs_sum;
  logic [AddrW-1:0] rel_sum;
  logic             br_s;
  logic             br_i1;
  logic             br_i2;
  logic [AddrW-1:0] br_old;
  logic [AddrW-1:0] br_new;
  logic             br_oor;
  logic [HalfW-1:0] br_lo;
  logic [HalfW-1:0] br_hi;
  logic [HalfW-1:0] mov_imm;
  logic [HalfW-1:0] mov_add;
  logic [HalfW-1:0] mov_sum;
  logic [HalfW-1:0] mov_lo;
  logic [HalfW-1:0] mov_hi;

  assign lo      = req_i.site_low_half;
  assign hi      = req_i.site_high_half;
  assign word    = {hi, lo};
  assign abs_sum = word + req_i.symbol_address;
  assign rel_sum = word + req_i.symbol_address - req_i.site_address;

  // thumb branch offset S:I1:I2:imm10:imm11:0, sign extended
  assign br_s   = lo[10];
  assign br_i1  = ~(hi[13] ^ br_s);
  assign br_i2  = ~(hi[11] ^ br_s);
  assign br_old = {{7{br_s}}, br_s, br_i1, br_i2, lo[9:0], hi[10:0], 1'b0};
  assign br_new = req_i.symbol_address + br_old - req_i.site_address;
  assign br_oor = !((&br_new[31:24]) || !(|br_new[31:24]));
  assign br_lo  = {lo[15:11], br_new[24], br_new[21:12]};
  assign br_hi  = {hi[15:14], ~(br_new[23] ^ br_new[24]), hi[12],
                   ~(br_new[22] ^ br_new[24]), br_new[11:1]};

  // imm16 = imm4:i:imm3:imm8
  assign mov_imm = {lo[3:0], lo[10], hi[14:12], hi[7:0]};
  assign mov_add = (req_i.opcode == RELOC_THM_MOVT) ? req_i.symbol_address[31:16]
                                                    : req_i.symbol_address[15:0];
  assign mov_sum = mov_imm + mov_add;
  assign mov_lo  = {lo[15:11], mov_sum[11], lo[9:4], mov_sum[15:12]};
  assign mov_hi  = {hi[15], mov_sum[10:8], hi[11:8], mov_sum[7:0]};

  always_comb begin
    rsp_o.patched_low_half  = lo;
    rsp_o.patched_high_half = hi;
    rsp_o.status            = ST_PATCHED;
    unique case (req_i.opcode) inside
      RELOC_ABS32, RELOC_TARGET1: begin
        rsp_o.patched_low_half  = abs_sum[15:0];
        rsp_o.patched_high_half = abs_sum[31:16];
      end
      RELOC_REL32: begin
        rsp_o.patched_low_half  = rel_sum[15:0];
        rsp_o.patched_high_half = rel_sum[31:16];
      end
      RELOC_THM_CALL, RELOC_THM_JUMP24: begin
        if (br_oor) begin
          rsp_o.status = ST_RANGE;
        end else begin
          rsp_o.patched_low_half  = br_lo;
          rsp_o.patched_high_half = br_hi;
        end
      end
      RELOC_THM_MOVW, RELOC_THM_MOVT: begin
        rsp_o.patched_low_half  = mov_lo;
        rsp_o.patched_high_half = mov_hi;
      end
      default: begin
        rsp_o.status = ST_UNSUPPORTED;
      end
    endcase
  end

endmodule
